FILE: design/pst_pkg.sv
`timescale 1ns / 1ps

package pst_pkg;

    // Field widths of the source and result beats
    localparam int BYTE_W        = 8;
    localparam int LINE_FIELD_W  = 16;
    localparam int COL_FIELD_W   = 12;

    // Default position widths
    localparam int LINE_WIDTH_DEF   = 16;
    localparam int COLUMN_WIDTH_DEF = 12;

    // Result queue depth (power of two, holds at least two beats)
    localparam int RES_FIFO_DEPTH = 4;

    typedef logic [BYTE_W-1:0]       byte_t;
    typedef logic [LINE_FIELD_W-1:0] line_t;
    typedef logic [COL_FIELD_W-1:0]  col_t;

    typedef enum logic [1:0] {
        MODE_SEARCH,
        MODE_WORD,
        MODE_STRING,
        MODE_ESCAPE
    } mode_t;

    // Result kinds
    localparam logic [1:0] EV_VALUE    = 2'd0;
    localparam logic [1:0] EV_COMPLETE = 2'd1;
    localparam logic [1:0] EV_ERROR    = 2'd2;

    // Token types
    localparam logic [3:0] TOK_PERIOD     = 4'd0;
    localparam logic [3:0] TOK_SEMICOLON  = 4'd1;
    localparam logic [3:0] TOK_OPEN       = 4'd2;
    localparam logic [3:0] TOK_CLOSE      = 4'd3;
    localparam logic [3:0] TOK_PROGRAM    = 4'd4;
    localparam logic [3:0] TOK_BEGIN      = 4'd5;
    localparam logic [3:0] TOK_END        = 4'd6;
    localparam logic [3:0] TOK_IDENT      = 4'd7;
    localparam logic [3:0] TOK_STRING     = 4'd8;
    localparam logic [3:0] TOK_STREAM_END = 4'd9;

    // Error codes
    localparam logic ERR_UNEXPECTED = 1'b0;
    localparam logic ERR_UNCLOSED   = 1'b1;

    // Keyword slots in the candidate mask
    localparam logic [1:0] KW_PROGRAM = 2'd0;
    localparam logic [1:0] KW_BEGIN   = 2'd1;
    localparam logic [1:0] KW_END     = 2'd2;
    localparam logic [2:0] KW_ALL     = 3'b111;
    localparam logic [2:0] WORD_LEN_MAX = 3'd7;

    // Characters
    localparam byte_t CH_PERIOD  = 8'h2E;
    localparam byte_t CH_SEMI    = 8'h3B;
    localparam byte_t CH_OPEN    = 8'h28;
    localparam byte_t CH_CLOSE   = 8'h29;
    localparam byte_t CH_QUOTE   = 8'h27;
    localparam byte_t CH_BSLASH  = 8'h5C;
    localparam byte_t CH_UNDER   = 8'h5F;
    localparam byte_t CH_SPACE   = 8'h20;
    localparam byte_t CH_TAB     = 8'h09;
    localparam byte_t CH_CR      = 8'h0D;
    localparam byte_t CH_LF      = 8'h0A;
    localparam byte_t CH_NUL     = 8'h00;
    localparam byte_t CH_LOW_N   = 8'h6E;
    localparam byte_t CH_LOW_T   = 8'h74;
    localparam byte_t CH_LOW_R   = 8'h72;
    localparam byte_t CH_ZERO    = 8'h30;

    typedef struct packed {
        byte_t src_byte;
        line_t src_line;
        col_t  src_column;
        logic  end_of_input;
    } src_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [3:0] token_type;
        byte_t      value_char;
        line_t      start_line;
        col_t       start_column;
        logic       error_code;
        logic       last;
    } res_t;

    // Lexer control state passed between the step logic and its registers
    typedef struct packed {
        mode_t      mode;
        logic [2:0] kw_match;
        logic [2:0] word_len;
        logic       halted;
    } lex_state_t;

    function automatic logic is_alpha(input byte_t c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
    endfunction

    function automatic logic is_alnum(input byte_t c);
        return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] len;
        case (k)
            KW_PROGRAM: len = 3'd7;
            KW_BEGIN:   len = 3'd5;
            KW_END:     len = 3'd3;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic byte_t kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [55:0] txt;
        case (k)
            KW_PROGRAM: txt = "program";
            KW_BEGIN:   txt = {"begin", 16'h0000};
            KW_END:     txt = {"end", 32'h00000000};
            default:    txt = '0;
        endcase
        return txt[55 - 8*idx -: 8];
    endfunction

    // Drop keyword candidates that the next character rules out
    function automatic logic [2:0] feed_kw(input logic [2:0] match, input logic [2:0] len,
                                           input byte_t c);
        logic [2:0] m;
        m = match;
        for (int k = 0; k < 3; k++) begin
            if (!(len < kw_len(2'(k)) && kw_char(2'(k), len) == c))
                m[k] = 1'b0;
        end
        return m;
    endfunction

    function automatic logic [3:0] classify(input logic [2:0] match, input logic [2:0] len);
        logic [3:0] t;
        if (match[KW_PROGRAM] && len == kw_len(KW_PROGRAM))
            t = TOK_PROGRAM;
        else if (match[KW_BEGIN] && len == kw_len(KW_BEGIN))
            t = TOK_BEGIN;
        else if (match[KW_END] && len == kw_len(KW_END))
            t = TOK_END;
        else
            t = TOK_IDENT;
        return t;
    endfunction

    function automatic byte_t unescape(input byte_t c);
        byte_t t;
        case (c)
            CH_LOW_N: t = CH_LF;
            CH_LOW_T: t = CH_TAB;
            CH_LOW_R: t = CH_CR;
            CH_ZERO:  t = CH_NUL;
            default:  t = c;
        endcase
        return t;
    endfunction

    function automatic res_t mk_res(input logic [1:0] kind, input logic [3:0] ttype,
                                    input byte_t ch, input line_t line, input col_t col,
                                    input logic code);
        res_t r;
        r.event_kind   = kind;
        r.token_type   = ttype;
        r.value_char   = ch;
        r.start_line   = line;
        r.start_column = col;
        r.error_code   = code;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

FILE: design/pst_lex_step.sv
`timescale 1ns / 1ps

module pst_lex_step #(
    parameter int LINE_WIDTH   = pst_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = pst_pkg::COLUMN_WIDTH_DEF,
    localparam int LW = (LINE_WIDTH < pst_pkg::LINE_FIELD_W) ? LINE_WIDTH
                                                              : pst_pkg::LINE_FIELD_W,
    localparam int CW = (COLUMN_WIDTH < pst_pkg::COL_FIELD_W) ? COLUMN_WIDTH
                                                               : pst_pkg::COL_FIELD_W
) (
    input  pst_pkg::src_t       item,
    input  pst_pkg::lex_state_t cur,
    input  logic [LW-1:0]       cur_line,
    input  logic [CW-1:0]       cur_col,
    output pst_pkg::lex_state_t nxt,
    output logic [LW-1:0]       nxt_line,
    output logic [CW-1:0]       nxt_col,
    output pst_pkg::res_t       res0,
    output pst_pkg::res_t       res1,
    output logic [1:0]          res_count
);

    pst_pkg::byte_t      c;
    logic [LW-1:0]       in_line;
    logic [CW-1:0]       in_col;
    pst_pkg::line_t      tok_line_w;
    pst_pkg::col_t       tok_col_w;

    // Searching-mode handling of the current byte
    pst_pkg::lex_state_t s_next;
    logic [LW-1:0]       s_line;
    logic [CW-1:0]       s_col;
    logic                s_emit;
    pst_pkg::res_t       s_res;

    assign c          = item.src_byte;
    assign in_line    = item.src_line[LW-1:0];
    assign in_col     = item.src_column[CW-1:0];
    assign tok_line_w = pst_pkg::line_t'(cur_line);
    assign tok_col_w  = pst_pkg::col_t'(cur_col);

    // Classify a byte seen outside any token
    always_comb
    begin
        pst_pkg::line_t pl;
        pst_pkg::col_t  pc;
        pl          = pst_pkg::line_t'(in_line);
        pc          = pst_pkg::col_t'(in_col);
        s_next      = cur;
        s_next.mode = pst_pkg::MODE_SEARCH;
        s_line      = cur_line;
        s_col       = cur_col;
        s_emit      = 1'b0;
        s_res       = '0;
        if (pst_pkg::is_alpha(c))
        begin
            s_next.mode     = pst_pkg::MODE_WORD;
            s_next.kw_match = pst_pkg::feed_kw(pst_pkg::KW_ALL, 3'd0, c);
            s_next.word_len = 3'd1;
            s_line          = in_line;
            s_col           = in_col;
            s_emit          = 1'b1;
            s_res = pst_pkg::mk_res(pst_pkg::EV_VALUE, pst_pkg::TOK_PERIOD, c, pl, pc, 1'b0);
        end
        else if (c == pst_pkg::CH_PERIOD)
        begin
            s_emit = 1'b1;
            s_res  = pst_pkg::mk_res(pst_pkg::EV_COMPLETE, pst_pkg::TOK_PERIOD, c, pl, pc,
                                     1'b0);
        end
        else if (c == pst_pkg::CH_SEMI)
        begin
            s_emit = 1'b1;
            s_res  = pst_pkg::mk_res(pst_pkg::EV_COMPLETE, pst_pkg::TOK_SEMICOLON, c, pl, pc,
                                     1'b0);
        end
        else if (c == pst_pkg::CH_OPEN)
        begin
            s_emit = 1'b1;
            s_res  = pst_pkg::mk_res(pst_pkg::EV_COMPLETE, pst_pkg::TOK_OPEN, c, pl, pc,
                                     1'b0);
        end
        else if (c == pst_pkg::CH_CLOSE)
        begin
            s_emit = 1'b1;
            s_res  = pst_pkg::mk_res(pst_pkg::EV_COMPLETE, pst_pkg::TOK_CLOSE, c, pl, pc,
                                     1'b0);
        end
        else if (c == pst_pkg::CH_QUOTE)
        begin
            s_next.mode = pst_pkg::MODE_STRING;
            s_line      = in_line;
            s_col       = in_col;
        end
        else if (c == pst_pkg::CH_SPACE || c == pst_pkg::CH_TAB ||
                 c == pst_pkg::CH_CR || c == pst_pkg::CH_LF)
        begin
            s_emit = 1'b0;
        end
        else
        begin
            s_next.halted = 1'b1;
            s_emit        = 1'b1;
            s_res = pst_pkg::mk_res(pst_pkg::EV_ERROR, pst_pkg::TOK_PERIOD, c, pl, pc,
                                    pst_pkg::ERR_UNEXPECTED);
        end
    end

    // Advance the lexer by one beat
    always_comb
    begin
        nxt       = cur;
        nxt_line  = cur_line;
        nxt_col   = cur_col;
        res0      = '0;
        res1      = '0;
        res_count = 2'd0;
        if (!cur.halted)
        begin
            if (item.end_of_input)
            begin
                if (cur.mode == pst_pkg::MODE_STRING || cur.mode == pst_pkg::MODE_ESCAPE)
                begin
                    res0 = pst_pkg::mk_res(pst_pkg::EV_ERROR, pst_pkg::TOK_PERIOD,
                                           pst_pkg::CH_NUL, tok_line_w, tok_col_w,
                                           pst_pkg::ERR_UNCLOSED);
                    res_count  = 2'd1;
                    nxt.halted = 1'b1;
                end
                else if (cur.mode == pst_pkg::MODE_WORD)
                begin
                    res0 = pst_pkg::mk_res(pst_pkg::EV_COMPLETE,
                                           pst_pkg::classify(cur.kw_match, cur.word_len),
                                           pst_pkg::CH_NUL, tok_line_w, tok_col_w, 1'b0);
                    res1 = pst_pkg::mk_res(pst_pkg::EV_COMPLETE, pst_pkg::TOK_STREAM_END,
                                           pst_pkg::CH_NUL, '0, '0, 1'b0);
                    res_count = 2'd2;
                    nxt.mode  = pst_pkg::MODE_SEARCH;
                end
                else
                begin
                    res0 = pst_pkg::mk_res(pst_pkg::EV_COMPLETE, pst_pkg::TOK_STREAM_END,
                                           pst_pkg::CH_NUL, '0, '0, 1'b0);
                    res_count = 2'd1;
                    nxt.mode  = pst_pkg::MODE_SEARCH;
                end
            end
            else
            begin
                case (cur.mode)
                    pst_pkg::MODE_WORD:
                    begin
                        if (pst_pkg::is_alnum(c))
                        begin
                            nxt.kw_match = pst_pkg::feed_kw(cur.kw_match, cur.word_len, c);
                            if (cur.word_len < pst_pkg::WORD_LEN_MAX)
                                nxt.word_len = cur.word_len + 3'd1;
                            res0 = pst_pkg::mk_res(pst_pkg::EV_VALUE, pst_pkg::TOK_PERIOD, c,
                                                   tok_line_w, tok_col_w, 1'b0);
                            res_count = 2'd1;
                        end
                        else
                        begin
                            // Close the word, then treat the byte as if searching
                            res0 = pst_pkg::mk_res(pst_pkg::EV_COMPLETE,
                                       pst_pkg::classify(cur.kw_match, cur.word_len),
                                       pst_pkg::CH_NUL, tok_line_w, tok_col_w, 1'b0);
                            res1      = s_res;
                            res_count = s_emit ? 2'd2 : 2'd1;
                            nxt       = s_next;
                            nxt_line  = s_line;
                            nxt_col   = s_col;
                        end
                    end
                    pst_pkg::MODE_STRING:
                    begin
                        if (c == pst_pkg::CH_QUOTE)
                        begin
                            res0 = pst_pkg::mk_res(pst_pkg::EV_COMPLETE, pst_pkg::TOK_STRING,
                                                   pst_pkg::CH_NUL, tok_line_w, tok_col_w,
                                                   1'b0);
                            res_count = 2'd1;
                            nxt.mode  = pst_pkg::MODE_SEARCH;
                        end
                        else if (c == pst_pkg::CH_BSLASH)
                        begin
                            nxt.mode = pst_pkg::MODE_ESCAPE;
                        end
                        else
                        begin
                            res0 = pst_pkg::mk_res(pst_pkg::EV_VALUE, pst_pkg::TOK_PERIOD, c,
                                                   tok_line_w, tok_col_w, 1'b0);
                            res_count = 2'd1;
                        end
                    end
                    pst_pkg::MODE_ESCAPE:
                    begin
                        res0 = pst_pkg::mk_res(pst_pkg::EV_VALUE, pst_pkg::TOK_PERIOD,
                                               pst_pkg::unescape(c), tok_line_w, tok_col_w,
                                               1'b0);
                        res_count = 2'd1;
                        nxt.mode  = pst_pkg::MODE_STRING;
                    end
                    pst_pkg::MODE_SEARCH:
                    begin
                        res0      = s_res;
                        res_count = s_emit ? 2'd1 : 2'd0;
                        nxt       = s_next;
                        nxt_line  = s_line;
                        nxt_col   = s_col;
                    end
                    default:
                    begin
                        nxt.mode = pst_pkg::MODE_SEARCH;
                    end
                endcase
            end
        end

        // Mark the final result of this beat
        if (res_count == 2'd1)
            res0.last = 1'b1;
        else if (res_count == 2'd2)
            res1.last = 1'b1;
    end

endmodule

FILE: design/pst_res_fifo.sv
`timescale 1ns / 1ps

module pst_res_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_count,
    input  pst_pkg::res_t push0,
    input  pst_pkg::res_t push1,
    output logic          room,
    output logic          res_valid,
    input  logic          res_stall,
    output pst_pkg::res_t res_data
);

    localparam int DEPTH = pst_pkg::RES_FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    pst_pkg::res_t   mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            pop;
    logic [PW-1:0]   wr_ptr_plus1;

    assign res_valid    = (count_reg != '0);
    assign res_data     = mem_reg[rd_ptr_reg];
    assign pop          = res_valid && !res_stall;
    assign room         = (count_reg <= CNTW'(DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CNTW'(push_count) - CNTW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store up to two result beats
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            mem_reg[wr_ptr_plus1] <= push1;
    end

endmodule

FILE: design/pascal_subset_tokenizer_top.sv
// An accepted source beat waits in the input register, then its results enter the queue.
// Throughput: one source beat per cycle while the queue has room; a beat that ends a word
//   and emits its own result yields two, so the result port paces at one per unstalled cycle.
// A four-entry result queue decouples the two sides; input is held while fewer than two
//   queue entries are free.
// Reset (rst_n, async, active low): searching, no token, not halted, queue empty.
`timescale 1ns / 1ps

module pascal_subset_tokenizer_top #(
    parameter int LINE_WIDTH   = pst_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = pst_pkg::COLUMN_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          src_valid,
    output logic          src_stall,
    input  pst_pkg::src_t src_data,
    output logic          res_valid,
    input  logic          res_stall,
    output pst_pkg::res_t res_data
);

    localparam int LW = (LINE_WIDTH < pst_pkg::LINE_FIELD_W) ? LINE_WIDTH
                                                              : pst_pkg::LINE_FIELD_W;
    localparam int CW = (COLUMN_WIDTH < pst_pkg::COL_FIELD_W) ? COLUMN_WIDTH
                                                               : pst_pkg::COL_FIELD_W;

    logic                in_valid_reg;
    logic                in_valid_next;
    pst_pkg::src_t       in_item_reg;

    pst_pkg::lex_state_t state_reg;
    pst_pkg::lex_state_t state_next;
    logic [LW-1:0]       tok_line_reg;
    logic [LW-1:0]       tok_line_next;
    logic [CW-1:0]       tok_col_reg;
    logic [CW-1:0]       tok_col_next;

    pst_pkg::res_t       res0;
    pst_pkg::res_t       res1;
    logic [1:0]          step_count;
    logic [1:0]          push_count;
    logic                room;
    logic                consume;
    logic                accept;

    assign consume    = in_valid_reg && room;
    assign src_stall  = in_valid_reg && !room;
    assign accept     = src_valid && !src_stall;
    assign push_count = consume ? step_count : 2'd0;

    // Input beat register
    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= src_data;
    end

    pst_lex_step #(
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_step (
        .item      (in_item_reg),
        .cur       (state_reg),
        .cur_line  (tok_line_reg),
        .cur_col   (tok_col_reg),
        .nxt       (state_next),
        .nxt_line  (tok_line_next),
        .nxt_col   (tok_col_next),
        .res0      (res0),
        .res1      (res1),
        .res_count (step_count)
    );

    // Lexer state, updated as each beat is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode     <= pst_pkg::MODE_SEARCH;
            state_reg.kw_match <= pst_pkg::KW_ALL;
            state_reg.word_len <= 3'd0;
            state_reg.halted   <= 1'b0;
            tok_line_reg       <= '0;
            tok_col_reg        <= '0;
        end
        else if (consume)
        begin
            state_reg    <= state_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
        end
    end

    pst_res_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room       (room),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule

FILE: design/pst_checker.sv
`timescale 1ns / 1ps

module pst_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          src_valid,
    input  logic          src_stall,
    input  pst_pkg::src_t src_data,
    input  logic          res_valid,
    input  logic          res_stall,
    input  pst_pkg::res_t res_data
);

    // Hold a stalled source beat
    a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_stall |=> src_valid && $stable(src_data))
        else $error("stalled source beat changed");

    // Hold a stalled result beat
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result beat changed");

    // An error always ends the results of its source beat
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.event_kind == pst_pkg::EV_ERROR |-> res_data.last)
        else $error("error beat not marked last");

    // A value character is the last result of its source beat, with zero token type and error code
    a_value_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.event_kind == pst_pkg::EV_VALUE |->
            res_data.last && res_data.token_type == pst_pkg::TOK_PERIOD &&
            !res_data.error_code)
        else $error("malformed value beat");

    // Stream end carries no position and closes its source beat
    a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.event_kind == pst_pkg::EV_COMPLETE &&
        res_data.token_type == pst_pkg::TOK_STREAM_END |->
            res_data.last && res_data.start_line == '0 && res_data.start_column == '0)
        else $error("malformed stream end beat");

endmodule

bind pascal_subset_tokenizer_top pst_checker u_pst_checker (.*);

FILE: tb/pascal_subset_tokenizer_top_tb.sv
`timescale 1ns / 1ps

module pascal_subset_tokenizer_top_tb;

    import pst_pkg::*;

    localparam int SOURCE_TARGET  = 1930;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    // Token predictor and store of expected result beats
    class lexer_scoreboard;
        mode_t      mode;
        logic [2:0] live;
        logic [2:0] word_len;
        line_t      tok_line;
        col_t       tok_col;
        bit         halted;
        string      kw_word[3];
        int         kw_size[3];
        logic [3:0] kw_tok[3];
        res_t       expected_events[$];
        int         mismatches;

        function new();
            kw_word[KW_PROGRAM] = "program";
            kw_word[KW_BEGIN]   = "begin";
            kw_word[KW_END]     = "end";
            kw_tok[KW_PROGRAM]  = TOK_PROGRAM;
            kw_tok[KW_BEGIN]    = TOK_BEGIN;
            kw_tok[KW_END]      = TOK_END;
            foreach (kw_word[k])
                kw_size[k] = kw_word[k].len();
            mode       = MODE_SEARCH;
            live       = KW_ALL;
            word_len   = '0;
            tok_line   = '0;
            tok_col    = '0;
            halted     = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        task report_mismatch(input string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        function bit letter(input byte_t c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
        endfunction

        function bit word_char(input byte_t c);
            return letter(c) || (c >= "0" && c <= "9");
        endfunction

        function void push(input logic [1:0] kind, input logic [3:0] tok, input byte_t ch,
                           input line_t line, input col_t col, input logic code);
            res_t r;
            r.event_kind   = kind;
            r.token_type   = tok;
            r.value_char   = ch;
            r.start_line   = line;
            r.start_column = col;
            r.error_code   = code;
            r.last         = 1'b0;
            expected_events.push_back(r);
        endfunction

        // Drop keyword candidates that no longer fit, then count the character
        function void advance_word(input byte_t c);
            for (int k = 0; k < 3; k++) begin
                if (live[k] && !(word_len < kw_size[k] && byte_t'(kw_word[k][word_len]) == c))
                    live[k] = 1'b0;
            end
            if (word_len != WORD_LEN_MAX)
                word_len++;
        endfunction

        function logic [3:0] word_token();
            for (int k = 0; k < 3; k++) begin
                if (live[k] && word_len == kw_size[k])
                    return kw_tok[k];
            end
            return TOK_IDENT;
        endfunction

        // Handle a byte seen while between tokens
        function void scan_byte(input src_t s);
            byte_t c;
            c = s.src_byte;
            if (letter(c)) begin
                mode     = MODE_WORD;
                tok_line = s.src_line;
                tok_col  = s.src_column;
                live     = KW_ALL;
                word_len = '0;
                advance_word(c);
                push(EV_VALUE, '0, c, tok_line, tok_col, '0);
            end
            else begin
                case (c)
                    CH_PERIOD: push(EV_COMPLETE, TOK_PERIOD, c, s.src_line, s.src_column, '0);
                    CH_SEMI:   push(EV_COMPLETE, TOK_SEMICOLON, c, s.src_line, s.src_column, '0);
                    CH_OPEN:   push(EV_COMPLETE, TOK_OPEN, c, s.src_line, s.src_column, '0);
                    CH_CLOSE:  push(EV_COMPLETE, TOK_CLOSE, c, s.src_line, s.src_column, '0);
                    CH_QUOTE:
                    begin
                        mode     = MODE_STRING;
                        tok_line = s.src_line;
                        tok_col  = s.src_column;
                    end
                    CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
                    default:
                    begin
                        push(EV_ERROR, '0, c, s.src_line, s.src_column, ERR_UNEXPECTED);
                        halted = 1'b1;
                    end
                endcase
            end
        endfunction

        // Work out the result beats of one accepted source beat
        function void note_source(input src_t s);
            int    first;
            byte_t c;
            byte_t t;
            res_t  tail;
            first = expected_events.size();
            c = s.src_byte;
            if (halted)
                return;
            if (s.end_of_input) begin
                if (mode == MODE_STRING || mode == MODE_ESCAPE) begin
                    push(EV_ERROR, '0, '0, tok_line, tok_col, ERR_UNCLOSED);
                    halted = 1'b1;
                end
                else begin
                    if (mode == MODE_WORD)
                        push(EV_COMPLETE, word_token(), '0, tok_line, tok_col, '0);
                    push(EV_COMPLETE, TOK_STREAM_END, '0, '0, '0, '0);
                    mode = MODE_SEARCH;
                end
            end
            else begin
                case (mode)
                    MODE_WORD:
                    begin
                        if (word_char(c)) begin
                            advance_word(c);
                            push(EV_VALUE, '0, c, tok_line, tok_col, '0);
                        end
                        else begin
                            push(EV_COMPLETE, word_token(), '0, tok_line, tok_col, '0);
                            mode = MODE_SEARCH;
                            scan_byte(s);
                        end
                    end
                    MODE_STRING:
                    begin
                        if (c == CH_QUOTE) begin
                            push(EV_COMPLETE, TOK_STRING, '0, tok_line, tok_col, '0);
                            mode = MODE_SEARCH;
                        end
                        else if (c == CH_BSLASH)
                            mode = MODE_ESCAPE;
                        else
                            push(EV_VALUE, '0, c, tok_line, tok_col, '0);
                    end
                    MODE_ESCAPE:
                    begin
                        case (c)
                            CH_LOW_N: t = CH_LF;
                            CH_LOW_T: t = CH_TAB;
                            CH_LOW_R: t = CH_CR;
                            CH_ZERO:  t = CH_NUL;
                            default:  t = c;
                        endcase
                        push(EV_VALUE, '0, t, tok_line, tok_col, '0);
                        mode = MODE_STRING;
                    end
                    default: scan_byte(s);
                endcase
            end
            // Mark the final beat of this step
            if (expected_events.size() > first) begin
                tail = expected_events.pop_back();
                tail.last = 1'b1;
                expected_events.push_back(tail);
            end
        endfunction

        // Compare one accepted result beat with the oldest expectation
        task check_result(input res_t got);
            res_t want;
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("result beat %h with none expected", got));
                return;
            end
            want = expected_events.pop_front();
            if (got.event_kind !== want.event_kind)
                report_mismatch($sformatf("event_kind got %0d want %0d",
                                          got.event_kind, want.event_kind));
            if (got.token_type !== want.token_type)
                report_mismatch($sformatf("token_type got %0d want %0d",
                                          got.token_type, want.token_type));
            if (got.value_char !== want.value_char)
                report_mismatch($sformatf("value_char got %h want %h",
                                          got.value_char, want.value_char));
            if (got.start_line !== want.start_line)
                report_mismatch($sformatf("start_line got %0d want %0d",
                                          got.start_line, want.start_line));
            if (got.start_column !== want.start_column)
                report_mismatch($sformatf("start_column got %0d want %0d",
                                          got.start_column, want.start_column));
            if (got.error_code !== want.error_code)
                report_mismatch($sformatf("error_code got %0d want %0d",
                                          got.error_code, want.error_code));
            if (got.last !== want.last)
                report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic src_valid;
    logic src_stall;
    src_t src_data;
    logic res_valid;
    logic res_stall;
    res_t res_data;

    lexer_scoreboard sb = new();
    int  source_count;
    int  idle_cycles;
    bit  calm;
    bit  extreme_positions;

    pascal_subset_tokenizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_draw();
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic byte_t random_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return byte_t'("a" + r);
        else if (r < 52)
            return byte_t'("A" + r - 26);
        return CH_UNDER;
    endfunction

    function automatic byte_t random_alnum();
        int r;
        r = $urandom_range(0, 62);
        if (r < 53)
            return random_letter();
        return byte_t'(CH_ZERO + r - 53);
    endfunction

    function automatic byte_t random_space();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic byte_t random_punct();
        case ($urandom_range(0, 3))
            0:       return CH_PERIOD;
            1:       return CH_SEMI;
            2:       return CH_OPEN;
            default: return CH_CLOSE;
        endcase
    endfunction

    // Drive one source beat and hold it until accepted
    task automatic send_source(input src_t beat);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            src_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_valid = 1'b1;
        src_data  = beat;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        sb.note_source(beat);
        source_count++;
        if ($urandom_range(0, 199) == 0)
            calm = !calm;
        @(negedge clk);
    endtask

    task automatic put_beat(input byte_t c, input bit eoi);
        src_t s;
        s.src_byte     = c;
        s.end_of_input = eoi;
        if (extreme_positions) begin
            s.src_line   = $urandom_range(0, 1) ? '1 : '0;
            s.src_column = $urandom_range(0, 1) ? '1 : '0;
        end
        else begin
            s.src_line   = line_t'($urandom_range(0, 65535));
            s.src_column = col_t'($urandom_range(0, 4095));
        end
        send_source(s);
    endtask

    task automatic put_byte(input byte_t c);
        put_beat(c, 1'b0);
    endtask

    task automatic put_end();
        put_beat(byte_t'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic put_text(input string text);
        for (int i = 0; i < text.len(); i++)
            put_byte(byte_t'(text[i]));
    endtask

    function automatic byte_t string_byte();
        byte_t c;
        do
            c = byte_t'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic byte_t escape_byte();
        case ($urandom_range(0, 5))
            0:       return CH_LOW_N;
            1:       return CH_LOW_T;
            2:       return CH_LOW_R;
            3:       return CH_ZERO;
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Emit a quoted string body with random bytes and escapes
    task automatic put_string_body(input int n);
        repeat (n) begin
            if ($urandom_range(0, 5) == 0) begin
                put_byte(CH_BSLASH);
                put_byte(escape_byte());
            end
            else
                put_byte(string_byte());
        end
    endtask

    // Emit a keyword, or one that is cut short, extended or has a case change
    task automatic put_keyword_like();
        string w;
        int    cut;
        int    flip;
        int    extra;
        case ($urandom_range(0, 2))
            0:       w = "program";
            1:       w = "begin";
            default: w = "end";
        endcase
        cut   = w.len();
        flip  = -1;
        extra = 0;
        case ($urandom_range(0, 4))
            0:       cut = $urandom_range(1, w.len() - 1);
            1:       extra = $urandom_range(1, 4);
            2:       flip = $urandom_range(0, w.len() - 1);
            default: ;
        endcase
        for (int i = 0; i < cut; i++)
            put_byte(i == flip ? byte_t'(w[i]) ^ 8'h20 : byte_t'(w[i]));
        repeat (extra)
            put_byte(random_alnum());
    endtask

    task automatic emit_random_token();
        case ($urandom_range(0, 11))
            0, 1:
            begin
                put_keyword_like();
                if ($urandom_range(0, 3) != 0)
                    put_byte(random_space());
            end
            2, 3, 4:
            begin
                put_byte(random_letter());
                repeat ($urandom_range(0, 11))
                    put_byte(random_alnum());
                if ($urandom_range(0, 3) != 0)
                    put_byte(random_space());
            end
            5, 6:
                put_byte(random_punct());
            7, 8:
            begin
                put_byte(CH_QUOTE);
                put_string_body($urandom_range(0, 8));
                put_byte(CH_QUOTE);
            end
            9, 10:
                repeat ($urandom_range(1, 3))
                    put_byte(random_space());
            default:
            begin
                if ($urandom_range(0, 2) == 0)
                    put_end();
                else
                    put_byte(random_space());
            end
        endcase
    endtask

    // Halt the block with one of the two error kinds
    task automatic put_error_tail();
        byte_t c;
        if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 1) == 0)
                put_byte(random_letter());
            do
                c = byte_t'($urandom_range(0, 255));
            while (sb.letter(c) || c == CH_PERIOD || c == CH_SEMI || c == CH_OPEN ||
                   c == CH_CLOSE || c == CH_QUOTE || c == CH_SPACE || c == CH_TAB ||
                   c == CH_CR || c == CH_LF);
            put_byte(c);
        end
        else begin
            put_byte(CH_QUOTE);
            put_string_body($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0)
                put_byte(CH_BSLASH);
            put_end();
        end
        // Feed more beats; a halted block must stay silent
        repeat (10)
            put_beat(byte_t'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    // Result side: stall at random, check every accepted beat
    initial
    begin
        int hold;
        hold = 0;
        res_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                res_stall = 1'b1;
                hold--;
            end
            else
                res_stall = 1'b0;
            @(posedge clk);
            if (rst_n && res_valid && !res_stall) begin
                sb.check_result(res_data);
                hold = idle_draw();
            end
        end
    end

    // Count cycles with no beat moving on either side
    initial
    begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || (src_valid && !src_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("pascal_subset_tokenizer_top regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        src_valid         = 1'b0;
        src_data          = '0;
        source_count      = 0;
        calm              = 1'b0;
        extreme_positions = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: keywords, punctuation, escapes, high bytes, end of input
        put_text("program;begin(end)");
        put_byte(CH_QUOTE);
        put_byte(CH_BSLASH);
        put_byte(CH_LOW_T);
        put_byte(8'hFF);
        put_byte(CH_QUOTE);
        put_byte(CH_UNDER);
        put_end();
        put_end();

        // Random token streams
        extreme_positions = 1'b0;
        while (source_count < SOURCE_TARGET)
            emit_random_token();
        put_error_tail();
        src_valid = 1'b0;

        // Drain the remaining results
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("pascal_subset_tokenizer_top regression: pass");
        else
            $display("pascal_subset_tokenizer_top regression: fail");
        $finish;
    end

endmodule
